/* sv/gaclc_pkg.sv */
// gaclc_pkg: shared types and constants of the gas alarm code lockout controller
// payload structs of both channels, configuration struct, register indexes and resets
// no dependencies
package gaclc_pkg;

   localparam int unsigned CSR_ADDR_WIDTH = 5;
   localparam int unsigned CSR_DATA_WIDTH = 32;

   typedef enum logic [2:0] {
      REG_FAST_BLINK   = 3'd0,
      REG_SLOW_BLINK   = 3'd1,
      REG_LOCKOUT      = 3'd2,
      REG_MAX_ATTEMPTS = 3'd3,
      REG_HOLDOFF      = 3'd4,
      REG_UNLOCK_CODE  = 3'd5
   } reg_index_type;

   localparam logic [9:0]  FAST_BLINK_RESET   = 10'd20;
   localparam logic [9:0]  SLOW_BLINK_RESET   = 10'd50;
   localparam logic [15:0] LOCKOUT_RESET      = 16'd6000;
   localparam logic [3:0]  MAX_ATTEMPTS_RESET = 4'd5;
   localparam logic [7:0]  HOLDOFF_RESET      = 8'd50;
   localparam logic [3:0]  UNLOCK_CODE_RESET  = 4'd3;

   localparam logic [3:0]  ALL_KEYS = 4'hF;

   typedef struct packed {
      logic gas;
      logic over_temp;
      logic enter;
      logic key_a;
      logic key_b;
      logic key_c;
      logic key_d;
   } req_type;

   typedef struct packed {
      logic alarm_led;
      logic emergency_led;
      logic blocked_led;
      logic locked_out;
   } rsp_type;

   typedef struct packed {
      logic [9:0]  fast_blink_ticks;
      logic [9:0]  slow_blink_ticks;
      logic [15:0] lockout_ticks;
      logic [3:0]  max_attempts;
      logic [7:0]  holdoff_ticks;
      logic [3:0]  unlock_code;
   } cfg_type;

endpackage

/* sv/gaclc_stream_if.sv */
// gaclc_stream_if: valid/ready channel carrying one payload per transfer
// payload type is set per instance; used with gaclc_pkg payload structs
interface gaclc_stream_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

/* sv/gas_alarm_code_lockout_controller_unit.sv */
// gas_alarm_code_lockout_controller_unit: top level of the gas alarm controller
// depends on gaclc_pkg, gaclc_stream_if, gaclc_csr, gaclc_core
//
// Each transfer on req_chan is one tick: sampled gas, over-temperature, enter
// and the four code keys. Each tick gives exactly one transfer on rsp_chan with
// the alarm, emergency and blocked LED levels and the lockout flag.
// A tick is captured in an input register; the state update then runs on it
// as one pass of compare and increment logic and the result is loaded into the
// output register, from which it transfers on rsp_chan.
// One tick is taken per cycle when rsp_chan keeps up; the rate is set by the
// state update feeding back on itself through the core state register.
// When rsp_chan stalls, the output register holds its result and one more tick
// waits in the input register; req_chan.ready drops only with both full.
// Reset clears both pipeline registers and all controller state and loads the
// register defaults. The user must write registers over the csr_ port (setup
// then access phase, no wait states) only with no tick in flight; it is unchecked.
module gas_alarm_code_lockout_controller_unit (
   input  logic                                 clock,
   input  logic                                 reset,
   gaclc_stream_if.sink                         req_chan,
   gaclc_stream_if.source                       rsp_chan,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [gaclc_pkg::CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  logic [gaclc_pkg::CSR_DATA_WIDTH-1:0] csr_pwdata,
   output logic [gaclc_pkg::CSR_DATA_WIDTH-1:0] csr_prdata,
   output logic                                 csr_pready
);

   gaclc_pkg::cfg_type cfg;
   gaclc_pkg::req_type tick_ff;
   gaclc_pkg::rsp_type result;
   gaclc_pkg::rsp_type out_ff;
   logic               tick_valid_ff;
   logic               tick_valid_in;
   logic               out_valid_ff;
   logic               out_valid_in;
   logic               advance;
   logic               req_fire;

   gaclc_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   gaclc_core u_core (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .tick    (tick_ff),
      .cfg     (cfg),
      .result  (result)
   );

   assign advance        = tick_valid_ff & (~out_valid_ff | rsp_chan.ready);
   assign req_chan.ready = ~tick_valid_ff | advance;
   assign req_fire       = req_chan.valid & req_chan.ready;

   assign tick_valid_in = req_fire | (tick_valid_ff & ~advance);
   assign out_valid_in  = advance | (out_valid_ff & ~rsp_chan.ready);

   assign rsp_chan.valid   = out_valid_ff;
   assign rsp_chan.payload = out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         tick_valid_ff <= tick_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         tick_ff <= req_chan.payload;
      end
      if (advance) begin
         out_ff <= result;
      end
   end

   // a held tick stays put until the state update takes it
   a_tick_holds: assert property (@(posedge clock) disable iff (reset)
      tick_valid_ff && !advance |=> tick_valid_ff && $stable(tick_ff))
      else $error("input register lost or changed a waiting tick");

   a_result_loaded: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_chan.valid && rsp_chan.payload == $past(result))
      else $error("result register not loaded after a state update");

   // lockout only follows emergency mode, which needs the alarm
   a_lockout_alarm: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.payload.locked_out |-> rsp_chan.payload.alarm_led)
      else $error("lockout reported without a latched alarm");

endmodule

/* sv/gaclc_csr.sv */
// gaclc_csr: APB-style configuration registers of the controller
// depends on gaclc_pkg
module gaclc_csr (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   csr_psel,
   input  logic                                   csr_penable,
   input  logic                                   csr_pwrite,
   input  logic [gaclc_pkg::CSR_ADDR_WIDTH-1:0]   csr_paddr,
   input  logic [gaclc_pkg::CSR_DATA_WIDTH-1:0]   csr_pwdata,
   output logic [gaclc_pkg::CSR_DATA_WIDTH-1:0]   csr_prdata,
   output logic                                   csr_pready,
   output gaclc_pkg::cfg_type                     cfg
);

   gaclc_pkg::cfg_type       cfg_ff;
   gaclc_pkg::cfg_type       cfg_in;
   gaclc_pkg::reg_index_type reg_index;
   logic                     write_en;

   assign reg_index  = gaclc_pkg::reg_index_type'(csr_paddr[gaclc_pkg::CSR_ADDR_WIDTH-1:2]);
   assign write_en   = csr_psel & csr_penable & csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (write_en) begin
         case (reg_index)
            gaclc_pkg::REG_FAST_BLINK:   cfg_in.fast_blink_ticks = csr_pwdata[9:0];
            gaclc_pkg::REG_SLOW_BLINK:   cfg_in.slow_blink_ticks = csr_pwdata[9:0];
            gaclc_pkg::REG_LOCKOUT:      cfg_in.lockout_ticks    = csr_pwdata[15:0];
            gaclc_pkg::REG_MAX_ATTEMPTS: cfg_in.max_attempts     = csr_pwdata[3:0];
            gaclc_pkg::REG_HOLDOFF:      cfg_in.holdoff_ticks    = csr_pwdata[7:0];
            gaclc_pkg::REG_UNLOCK_CODE:  cfg_in.unlock_code      = csr_pwdata[3:0];
            default:                     cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (reg_index)
         gaclc_pkg::REG_FAST_BLINK:   csr_prdata = {22'd0, cfg_ff.fast_blink_ticks};
         gaclc_pkg::REG_SLOW_BLINK:   csr_prdata = {22'd0, cfg_ff.slow_blink_ticks};
         gaclc_pkg::REG_LOCKOUT:      csr_prdata = {16'd0, cfg_ff.lockout_ticks};
         gaclc_pkg::REG_MAX_ATTEMPTS: csr_prdata = {28'd0, cfg_ff.max_attempts};
         gaclc_pkg::REG_HOLDOFF:      csr_prdata = {24'd0, cfg_ff.holdoff_ticks};
         gaclc_pkg::REG_UNLOCK_CODE:  csr_prdata = {28'd0, cfg_ff.unlock_code};
         default:                     csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.fast_blink_ticks <= gaclc_pkg::FAST_BLINK_RESET;
         cfg_ff.slow_blink_ticks <= gaclc_pkg::SLOW_BLINK_RESET;
         cfg_ff.lockout_ticks    <= gaclc_pkg::LOCKOUT_RESET;
         cfg_ff.max_attempts     <= gaclc_pkg::MAX_ATTEMPTS_RESET;
         cfg_ff.holdoff_ticks    <= gaclc_pkg::HOLDOFF_RESET;
         cfg_ff.unlock_code      <= gaclc_pkg::UNLOCK_CODE_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

/* sv/gaclc_core.sv */
// gaclc_core: controller state and the per-tick next-state logic
// depends on gaclc_pkg
module gaclc_core (
   input  logic                clock,
   input  logic                reset,
   input  logic                advance,
   input  gaclc_pkg::req_type  tick,
   input  gaclc_pkg::cfg_type  cfg,
   output gaclc_pkg::rsp_type  result
);

   typedef struct packed {
      logic        alarm_latched;
      logic        emergency_active;
      logic        lockout_active;
      logic [3:0]  wrong_count;
      logic        fast_phase;
      logic        slow_phase;
      logic        emergency_led_reg;
      logic        blocked_led_reg;
      logic [9:0]  fast_timer;
      logic [9:0]  slow_timer;
      logic [15:0] lockout_timer;
      logic [8:0]  holdoff_count;
   } state_type;

   state_type  st_ff;
   state_type  st_in;
   logic [3:0] keys;
   logic [3:0] wrong_inc;

   assign keys      = {tick.key_d, tick.key_c, tick.key_b, tick.key_a};
   assign wrong_inc = (st_ff.wrong_count == 4'hF) ? 4'hF : st_ff.wrong_count + 4'd1;

   always_comb begin
      st_in = st_ff;
      st_in.fast_timer = (st_ff.fast_timer == '1) ? st_ff.fast_timer
                                                   : st_ff.fast_timer + 10'd1;
      st_in.slow_timer = (st_ff.slow_timer == '1) ? st_ff.slow_timer
                                                   : st_ff.slow_timer + 10'd1;
      if (st_ff.lockout_active && st_ff.lockout_timer != '1) begin
         st_in.lockout_timer = st_ff.lockout_timer + 16'd1;
      end

      if (st_ff.holdoff_count != '0) begin
         // hold-off: inputs ignored, timers keep running
         st_in.holdoff_count = st_ff.holdoff_count - 9'd1;
         if (st_in.holdoff_count <= {1'b0, cfg.holdoff_ticks} && !st_ff.lockout_active) begin
            st_in.blocked_led_reg = 1'b0;
         end
      end else begin
         if (tick.gas | tick.over_temp) begin
            st_in.alarm_latched = 1'b1;
         end
         if (tick.gas & tick.over_temp) begin
            st_in.emergency_active = 1'b1;
         end

         if (st_in.emergency_active && !st_ff.lockout_active) begin
            if (st_in.fast_timer >= cfg.fast_blink_ticks) begin
               st_in.fast_phase        = ~st_ff.fast_phase;
               st_in.emergency_led_reg = ~st_ff.fast_phase;
               st_in.fast_timer        = '0;
            end
         end else begin
            st_in.emergency_led_reg = 1'b0;
         end

         // all-keys reset
         if (!st_ff.lockout_active && st_ff.wrong_count < cfg.max_attempts &&
             keys == gaclc_pkg::ALL_KEYS && !tick.enter) begin
            st_in.emergency_active  = 1'b0;
            st_in.emergency_led_reg = 1'b0;
         end

         if (!st_ff.lockout_active && tick.enter && st_in.emergency_active) begin
            if (keys == cfg.unlock_code) begin
               st_in.emergency_active  = 1'b0;
               st_in.emergency_led_reg = 1'b0;
               st_in.wrong_count       = '0;
               st_in.blocked_led_reg   = 1'b0;
               st_in.holdoff_count     = {1'b0, cfg.holdoff_ticks};
            end else if (wrong_inc >= cfg.max_attempts) begin
               st_in.wrong_count    = cfg.max_attempts;
               st_in.lockout_active = 1'b1;
               st_in.lockout_timer  = '0;
               st_in.slow_timer     = '0;
               st_in.holdoff_count  = {1'b0, cfg.holdoff_ticks};
            end else begin
               st_in.wrong_count     = wrong_inc;
               st_in.blocked_led_reg = (cfg.holdoff_ticks != '0);
               st_in.holdoff_count   = {cfg.holdoff_ticks, 1'b0};
            end
         end

         if (st_in.lockout_active) begin
            if (st_in.lockout_timer >= cfg.lockout_ticks) begin
               st_in.lockout_active  = 1'b0;
               st_in.wrong_count     = '0;
               st_in.blocked_led_reg = 1'b0;
               st_in.lockout_timer   = '0;
            end else if (st_in.slow_timer >= cfg.slow_blink_ticks) begin
               st_in.slow_phase      = ~st_ff.slow_phase;
               st_in.blocked_led_reg = ~st_ff.slow_phase;
               st_in.slow_timer      = '0;
            end
         end
      end
   end

   assign result.alarm_led     = st_in.alarm_latched;
   assign result.emergency_led = st_in.emergency_led_reg;
   assign result.blocked_led   = st_in.blocked_led_reg;
   assign result.locked_out    = st_in.lockout_active;

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= '0;
      end else if (advance) begin
         st_ff <= st_in;
      end
   end

endmodule

/* tb/sv/gas_alarm_code_lockout_controller_unit_tb.sv */
// gas_alarm_code_lockout_controller_unit_tb: self-checking bench for the gas alarm controller
// drives ticks and csr writes, predicts every led result and checks it in order
// depends on gaclc_pkg, gaclc_stream_if and gas_alarm_code_lockout_controller_unit
module gas_alarm_code_lockout_controller_unit_tb;
   import gaclc_pkg::*;

   class led_scoreboard;
      cfg_type     cfg;
      logic        alarm_latched, emergency_active, lockout_active;
      logic [3:0]  wrong_count;
      logic        fast_phase, slow_phase, emergency_led_q, blocked_led_q;
      logic [9:0]  fast_timer, slow_timer;
      logic [15:0] lockout_timer;
      logic [8:0]  holdoff_count;
      rsp_type     led_queue[$];
      int unsigned mismatches;

      function new();
         cfg.fast_blink_ticks = FAST_BLINK_RESET;
         cfg.slow_blink_ticks = SLOW_BLINK_RESET;
         cfg.lockout_ticks    = LOCKOUT_RESET;
         cfg.max_attempts     = MAX_ATTEMPTS_RESET;
         cfg.holdoff_ticks    = HOLDOFF_RESET;
         cfg.unlock_code      = UNLOCK_CODE_RESET;
         alarm_latched = 1'b0; emergency_active = 1'b0; lockout_active = 1'b0;
         wrong_count = '0; fast_phase = 1'b0; slow_phase = 1'b0;
         emergency_led_q = 1'b0; blocked_led_q = 1'b0;
         fast_timer = '0; slow_timer = '0; lockout_timer = '0; holdoff_count = '0;
         mismatches = 0;
      endfunction

      function void set_reg(reg_index_type idx, logic [31:0] value);
         case (idx)
            REG_FAST_BLINK:   cfg.fast_blink_ticks = value[9:0];
            REG_SLOW_BLINK:   cfg.slow_blink_ticks = value[9:0];
            REG_LOCKOUT:      cfg.lockout_ticks    = value[15:0];
            REG_MAX_ATTEMPTS: cfg.max_attempts     = value[3:0];
            REG_HOLDOFF:      cfg.holdoff_ticks    = value[7:0];
            REG_UNLOCK_CODE:  cfg.unlock_code      = value[3:0];
            default: ;
         endcase
      endfunction

      function void flag(string what);
         mismatches++;
         if (mismatches <= 10) $display("mismatch: %s", what);
      endfunction

      function rsp_type next_leds(req_type t);
         logic [3:0] keys;
         logic [3:0] n;
         rsp_type    r;
         keys = {t.key_d, t.key_c, t.key_b, t.key_a};
         if (fast_timer != 10'h3FF) fast_timer++;
         if (slow_timer != 10'h3FF) slow_timer++;
         if (lockout_active && lockout_timer != 16'hFFFF) lockout_timer++;
         if (holdoff_count != 9'd0) begin
            holdoff_count--;
            if (holdoff_count <= {1'b0, cfg.holdoff_ticks} && !lockout_active)
               blocked_led_q = 1'b0;
         end else begin
            if (t.gas | t.over_temp) alarm_latched = 1'b1;
            if (t.gas & t.over_temp) emergency_active = 1'b1;
            if (emergency_active && !lockout_active) begin
               if (fast_timer >= cfg.fast_blink_ticks) begin
                  fast_phase = ~fast_phase;
                  emergency_led_q = fast_phase;
                  fast_timer = '0;
               end
            end else begin
               emergency_led_q = 1'b0;
            end
            if (!lockout_active && wrong_count < cfg.max_attempts && keys == ALL_KEYS &&
                !t.enter) begin
               emergency_active = 1'b0;
               emergency_led_q = 1'b0;
            end
            if (!lockout_active && t.enter && emergency_active) begin
               if (keys == cfg.unlock_code) begin
                  emergency_active = 1'b0;
                  emergency_led_q = 1'b0;
                  wrong_count = '0;
                  blocked_led_q = 1'b0;
                  holdoff_count = {1'b0, cfg.holdoff_ticks};
               end else begin
                  n = (wrong_count == 4'hF) ? 4'hF : wrong_count + 4'd1;
                  if (n >= cfg.max_attempts) begin
                     wrong_count = cfg.max_attempts;
                     lockout_active = 1'b1;
                     lockout_timer = '0;
                     slow_timer = '0;
                     holdoff_count = {1'b0, cfg.holdoff_ticks};
                  end else begin
                     wrong_count = n;
                     blocked_led_q = (cfg.holdoff_ticks != 8'd0);
                     holdoff_count = {cfg.holdoff_ticks, 1'b0};
                  end
               end
            end
            if (lockout_active) begin
               if (lockout_timer >= cfg.lockout_ticks) begin
                  lockout_active = 1'b0;
                  wrong_count = '0;
                  blocked_led_q = 1'b0;
                  lockout_timer = '0;
               end else if (slow_timer >= cfg.slow_blink_ticks) begin
                  slow_phase = ~slow_phase;
                  blocked_led_q = slow_phase;
                  slow_timer = '0;
               end
            end
         end
         r.alarm_led     = alarm_latched;
         r.emergency_led = emergency_led_q;
         r.blocked_led   = blocked_led_q;
         r.locked_out    = lockout_active;
         return r;
      endfunction

      function void note_tick(req_type t);
         led_queue.push_back(next_leds(t));
      endfunction

      function void check_result(rsp_type got);
         rsp_type want;
         if (led_queue.size() == 0) begin
            flag($sformatf("result %b with no tick pending", got));
            return;
         end
         want = led_queue.pop_front();
         if (got.alarm_led !== want.alarm_led || got.emergency_led !== want.emergency_led ||
             got.blocked_led !== want.blocked_led || got.locked_out !== want.locked_out)
            flag($sformatf("alarm/emergency/blocked/locked expected %b actual %b", want, got));
      endfunction

      function void check_drained();
         if (led_queue.size() != 0)
            flag($sformatf("%0d results never arrived", led_queue.size()));
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;
   logic                      csr_psel, csr_penable, csr_pwrite;
   logic [CSR_ADDR_WIDTH-1:0] csr_paddr;
   logic [CSR_DATA_WIDTH-1:0] csr_pwdata;
   logic [CSR_DATA_WIDTH-1:0] csr_prdata;
   logic                      csr_pready;
   bit                        calm;

   led_scoreboard sb = new();

   gaclc_stream_if #(.payload_type(req_type)) req_if ();
   gaclc_stream_if #(.payload_type(rsp_type)) rsp_if ();

   gas_alarm_code_lockout_controller_unit dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_if),
      .rsp_chan    (rsp_if),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(negedge clock) rsp_if.ready <= calm || ($urandom_range(99) >= 27);

   always @(posedge clock) begin
      if (!reset) begin
         if (req_if.valid && req_if.ready) sb.note_tick(req_if.payload);
         if (rsp_if.valid && rsp_if.ready) sb.check_result(rsp_if.payload);
      end
   end

   function automatic req_type make_tick(logic gas, logic hot, logic enter, logic [3:0] keys);
      req_type t;
      t.gas = gas; t.over_temp = hot; t.enter = enter;
      t.key_a = keys[0]; t.key_b = keys[1]; t.key_c = keys[2]; t.key_d = keys[3];
      return t;
   endfunction

   function automatic req_type random_tick();
      int unsigned pick;
      pick = $urandom_range(99);
      if (pick < 15) return req_type'($urandom_range(127));
      if (pick < 30) return make_tick(1'b1, 1'b1, 1'b0, 4'($urandom_range(14)));
      if (pick < 45) return make_tick($urandom_range(9) == 0, $urandom_range(9) == 0, 1'b1,
                                      sb.cfg.unlock_code);
      if (pick < 63) return make_tick(1'b0, 1'b0, 1'b1, 4'($urandom_range(15)));
      if (pick < 73) return make_tick($urandom_range(9) == 0, 1'b0, 1'b0, ALL_KEYS);
      return make_tick($urandom_range(19) == 0, $urandom_range(19) == 0, 1'b0, 4'd0);
   endfunction

   task automatic send_tick(input req_type t);
      while (!calm && $urandom_range(99) < 27) begin
         req_if.valid <= 1'b0;
         @(negedge clock);
      end
      req_if.valid   <= 1'b1;
      req_if.payload <= t;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_csr(input reg_index_type idx, input logic [31:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CSR_ADDR_WIDTH'({idx, 2'b00});
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      sb.set_reg(idx, value);
      @(negedge clock);
   endtask

   task automatic apply_cfg(input cfg_type c);
      write_csr(REG_FAST_BLINK, 32'(c.fast_blink_ticks));
      write_csr(REG_SLOW_BLINK, 32'(c.slow_blink_ticks));
      write_csr(REG_LOCKOUT, 32'(c.lockout_ticks));
      write_csr(REG_MAX_ATTEMPTS, 32'(c.max_attempts));
      write_csr(REG_HOLDOFF, 32'(c.holdoff_ticks));
      write_csr(REG_UNLOCK_CODE, 32'(c.unlock_code));
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   task automatic drain_results();
      req_if.valid <= 1'b0;
      while (sb.led_queue.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   initial begin
      req_type     directed[$];
      cfg_type     c;
      int unsigned count;
      reset          = 1'b1;
      req_if.valid   = 1'b0;
      req_if.payload = '0;
      rsp_if.ready   = 1'b0;
      csr_psel       = 1'b0;
      csr_penable    = 1'b0;
      csr_pwrite     = 1'b0;
      csr_paddr      = '0;
      csr_pwdata     = '0;
      calm           = 1'b0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed walk: alarm, emergency, key reset, wrong code, good code, lockout
      c = '{fast_blink_ticks: 10'd2, slow_blink_ticks: 10'd2, lockout_ticks: 16'd6,
            max_attempts: 4'd2, holdoff_ticks: 8'd1, unlock_code: 4'd5};
      apply_cfg(c);
      directed = '{make_tick(1'b0, 1'b0, 1'b0, 4'h0), make_tick(1'b1, 1'b0, 1'b0, 4'h0),
                   make_tick(1'b0, 1'b1, 1'b0, 4'h0), make_tick(1'b1, 1'b1, 1'b0, 4'h0),
                   make_tick(1'b0, 1'b0, 1'b0, 4'h0), make_tick(1'b0, 1'b0, 1'b0, 4'h0),
                   make_tick(1'b0, 1'b0, 1'b0, 4'hF), make_tick(1'b1, 1'b1, 1'b0, 4'h0),
                   make_tick(1'b0, 1'b0, 1'b1, 4'h9), make_tick(1'b0, 1'b0, 1'b0, 4'h0),
                   make_tick(1'b0, 1'b0, 1'b0, 4'h0), make_tick(1'b0, 1'b0, 1'b1, 4'h5),
                   make_tick(1'b1, 1'b1, 1'b0, 4'h0), make_tick(1'b0, 1'b0, 1'b1, 4'h0),
                   make_tick(1'b0, 1'b0, 1'b0, 4'h0), make_tick(1'b0, 1'b0, 1'b0, 4'h0),
                   make_tick(1'b1, 1'b1, 1'b1, 4'hF), make_tick(1'b0, 1'b0, 1'b0, 4'hF),
                   make_tick(1'b0, 1'b0, 1'b0, 4'h0), make_tick(1'b0, 1'b0, 1'b0, 4'h0),
                   make_tick(1'b0, 1'b0, 1'b0, 4'h0), make_tick(1'b0, 1'b0, 1'b0, 4'h0),
                   make_tick(1'b1, 1'b1, 1'b1, 4'hF), make_tick(1'b0, 1'b0, 1'b0, 4'h0)};
      foreach (directed[i]) send_tick(directed[i]);
      drain_results();

      for (int phase = 0; phase < 11; phase++) begin
         case (phase)
            0: c = '{10'd1, 10'd1, 16'd1, 4'd1, 8'd0, 4'd0};
            1: c = '{10'd1023, 10'd1023, 16'd65535, 4'd15, 8'd255, 4'd15};
            2: c = '{10'd0, 10'd0, 16'd0, 4'd0, 8'd1, 4'($urandom_range(15))};
            10: c = '{FAST_BLINK_RESET, SLOW_BLINK_RESET, LOCKOUT_RESET,
                      MAX_ATTEMPTS_RESET, HOLDOFF_RESET, UNLOCK_CODE_RESET};
            default: c = '{10'($urandom_range(8, 1)), 10'($urandom_range(8, 1)),
                           16'($urandom_range(60, 1)), 4'($urandom_range(4, 1)),
                           8'($urandom_range(6)), 4'($urandom_range(15))};
         endcase
         apply_cfg(c);
         calm  = (phase == 5);
         count = (phase == 1 || phase == 10) ? 150 : 190;
         for (int k = 0; k < count; k++) begin
            if (phase == 6 && k == 100) drain_results();
            send_tick(random_tick());
         end
         drain_results();
      end
      calm = 1'b0;

      sb.check_drained();
      if (sb.mismatches == 0)
         $display("gas_alarm_code_lockout_controller_unit_tb: clean");
      else
         $display("gas_alarm_code_lockout_controller_unit_tb: errors");
      $finish;
   end

   initial begin
      #5000000;
      $display("gas_alarm_code_lockout_controller_unit_tb: errors");
      $finish;
   end

endmodule
